// ===== src/thfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-header frame deframer package
// Shared types and constants for the deframer front end, queue and top level.
// ----------------------------------------------------------------------------
package thfd_pkg;

  localparam logic [7:0] ShortStartReset = 8'h5A;
  localparam logic [7:0] LongStartReset  = 8'h5B;

  localparam logic RegShortStart = 1'b0;
  localparam logic RegLongStart  = 1'b1;

  localparam logic [1:0] KindData  = 2'd0;
  localparam logic [1:0] KindEmpty = 2'd1;
  localparam logic [1:0] KindDrop  = 2'd2;

  typedef enum logic [2:0] {
    PhHunt    = 3'd0,
    PhCmd     = 3'd1,
    PhLenLo   = 3'd2,
    PhLenHi   = 3'd3,
    PhPayload = 3'd4
  } phase_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       capture_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] frame_command;
    logic [7:0] payload_byte;
    logic [1:0] kind;
    logic       first_of_frame;
    logic       last_of_frame;
    logic       long_header;
  } out_word_t;

  typedef struct packed {
    logic [7:0] short_start_byte;
    logic [7:0] long_start_byte;
  } start_cfg_t;

endpackage

// ===== src/two_header_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// Two-header frame deframer
// Takes link bytes, finds short- or long-header frames and emits tagged words.
//
// Input side is a queue: drive in_word_i and push; a word is taken when push
// is high and full is low. One word per cycle is sustained until full rises.
// Result side is a queue: while empty is low the oldest result is on
// out_word_o; pop takes it. Each input word yields zero or one result.
// A result can be popped in the cycle after its word is taken.
// Throughput: one word per cycle unless full; the front end decodes each
// byte combinationally and the result queue (FifoDepth entries) absorbs
// receiver stalls; if they last long enough, the queue fills and full rises.
// Configuration: cfg_index_i selects short (0) or long (1) start byte;
// cfg_ready is always high. Write only while idle.
// Reset: start bytes return to 0x5A and 0x5B, the parser hunts, the queue
// empties.
// ----------------------------------------------------------------------------
module two_header_frame_deframer
  import thfd_pkg::*;
#(
  parameter int FifoDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  in_word_t   in_word_i,
  output logic       empty,
  input  logic       pop,
  output out_word_t  out_word_o,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  start_cfg_t cfg_q;
  logic       in_acc;
  logic       res_valid;
  out_word_t  res;

  assign cfg_ready = 1'b1;
  assign in_acc    = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_start_byte <= ShortStartReset;
      cfg_q.long_start_byte  <= LongStartReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_i)
        RegShortStart: cfg_q.short_start_byte <= cfg_data_i;
        RegLongStart:  cfg_q.long_start_byte  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  thfd_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_acc),
    .in_word_i  (in_word_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  thfd_fifo #(
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (in_acc && res_valid),
    .wr_data_i(res),
    .rd_i     (pop),
    .rd_data_o(out_word_o),
    .full_o   (full),
    .empty_o  (empty)
  );

endmodule

// ===== src/thfd_parser.sv =====
// ----------------------------------------------------------------------------
// Deframer front end
// Hunts for start bytes, decodes the header and tags payload bytes.
// ----------------------------------------------------------------------------
module thfd_parser
  import thfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  start_cfg_t cfg_i,
  input  logic       in_valid_i,
  input  in_word_t   in_word_i,
  output logic       res_valid_o,
  output out_word_t  res_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] left_q, left_d;
  logic        long_q, long_d;
  logic        first_q, first_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      cmd_q   <= 8'd0;
      left_q  <= 16'd0;
      long_q  <= 1'b0;
      first_q <= 1'b0;
    end else if (in_valid_i) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      left_q  <= left_d;
      long_q  <= long_d;
      first_q <= first_d;
    end
  end

  always_comb begin
    logic [7:0]  b;
    logic        cap;
    logic        drop_first;
    logic [15:0] len;
    b          = in_word_i.rx_byte;
    cap        = in_word_i.capture_end;
    drop_first = 1'b1;
    len        = 16'd0;
    phase_d    = phase_q;
    cmd_d      = cmd_q;
    left_d     = left_q;
    long_d     = long_q;
    first_d    = first_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    case (phase_q)
      PhCmd: begin
        cmd_d   = b;
        phase_d = PhLenLo;
      end
      PhLenLo, PhLenHi: begin
        if (phase_q == PhLenLo && long_q) begin
          left_d  = {8'd0, b};
          phase_d = PhLenHi;
        end else begin
          len = (phase_q == PhLenLo) ? {8'd0, b} : {b, left_q[7:0]};
          if (len == 16'd0) begin
            res_valid_o = 1'b1;
            res_o = '{frame_command: cmd_q, payload_byte: 8'd0, kind: KindEmpty,
                      first_of_frame: 1'b1, last_of_frame: 1'b1, long_header: long_q};
            phase_d = PhHunt;
            cmd_d   = 8'd0;
            left_d  = 16'd0;
            long_d  = 1'b0;
            first_d = 1'b0;
          end else begin
            left_d  = len;
            first_d = 1'b1;
            phase_d = PhPayload;
          end
        end
      end
      PhPayload: begin
        drop_first = first_q;
        if (left_q[15:1] == 15'd0 || !cap) begin
          res_valid_o = 1'b1;
          res_o = '{frame_command: cmd_q, payload_byte: b, kind: KindData,
                    first_of_frame: first_q, last_of_frame: (left_q[15:1] == 15'd0),
                    long_header: long_q};
          first_d = 1'b0;
          if (left_q[15:1] == 15'd0) begin
            phase_d = PhHunt;
            cmd_d   = 8'd0;
            left_d  = 16'd0;
            long_d  = 1'b0;
          end else begin
            left_d = left_q - 16'd1;
          end
        end
      end
      default: begin
        phase_d = PhHunt;
        cmd_d   = 8'd0;
        left_d  = 16'd0;
        long_d  = 1'b0;
        first_d = 1'b0;
        if (b == cfg_i.short_start_byte) begin
          phase_d = PhCmd;
        end else if (b == cfg_i.long_start_byte) begin
          long_d  = 1'b1;
          phase_d = PhCmd;
        end
      end
    endcase

    if (cap && phase_d != PhHunt) begin
      res_valid_o = 1'b1;
      res_o = '{frame_command: cmd_d, payload_byte: 8'd0, kind: KindDrop,
                first_of_frame: drop_first, last_of_frame: 1'b1, long_header: long_d};
      phase_d = PhHunt;
      cmd_d   = 8'd0;
      left_d  = 16'd0;
      long_d  = 1'b0;
      first_d = 1'b0;
    end
  end

endmodule

// ===== src/thfd_fifo.sv =====
// ----------------------------------------------------------------------------
// Deframer result queue
// Holds tagged words between the front end and the result port.
// ----------------------------------------------------------------------------
module thfd_fifo
  import thfd_pkg::*;
#(
  parameter int Depth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_i,
  input  out_word_t wr_data_i,
  input  logic      rd_i,
  output out_word_t rd_data_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  out_word_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == FullCnt);
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
